/* hdl/hex_number_formatter_core_defines.svh */
// ----------------------------------------------------------------------------
// Hex number formatter assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HEX_NUMBER_FORMATTER_CORE_DEFINES_SVH
`define HEX_NUMBER_FORMATTER_CORE_DEFINES_SVH

// same-cycle implication
`define HNF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HNF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/hnf_pkg.sv */
// ----------------------------------------------------------------------------
// Hex number formatter package
// Shared types, register indexes and character constants.
// ----------------------------------------------------------------------------
package hnf_pkg;

  localparam int NUM_W     = 64;
  localparam int NIBBLES   = 16;
  localparam int CHAR_W    = 16;
  localparam int CNT_W     = 5;   // holds 0..16
  localparam int PRE_IDX_W = 3;   // prefix_length field width
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;

  localparam logic [CNT_W-1:0]  MAX_DIGITS = 5'd16;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 16'h0020;

  localparam logic [CHAR_W-1:0] HEX_GLYPHS [NIBBLES] = '{
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DIGITS    = 2'd0,
    CFG_GROUPING_ON   = 2'd1,
    CFG_PREFIX_LENGTH = 2'd2,
    CFG_PREFIX_CHARS  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]     min_digits;
    logic                 grouping_on;
    logic [PRE_IDX_W-1:0] prefix_length;
    logic [NUM_W-1:0]     prefix_chars;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] value;
    logic [CNT_W-1:0] sig;   // significant nibbles, 1..16
  } item_t;

endpackage

/* hdl/hnf_num_if.sv */
// ----------------------------------------------------------------------------
// Number channel
// valid/ready channel carrying one signed 64-bit value per beat.
// ----------------------------------------------------------------------------
interface hnf_num_if;
  logic                                valid;
  logic                                ready;
  logic signed [hnf_pkg::NUM_W-1:0]    number_in;

  modport source (output valid, output number_in, input ready);
  modport sink   (input valid, input number_in, output ready);
endinterface

/* hdl/hnf_char_if.sv */
// ----------------------------------------------------------------------------
// Character channel
// valid/ready channel carrying one character code and a last flag per beat.
// ----------------------------------------------------------------------------
interface hnf_char_if;
  logic                          valid;
  logic                          ready;
  logic [hnf_pkg::CHAR_W-1:0]    out_char;
  logic                          is_last;

  modport source (output valid, output out_char, output is_last, input ready);
  modport sink   (input valid, input out_char, input is_last, output ready);
endinterface

/* hdl/hnf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Hex formatter configuration registers
// Write-only register bank; min_digits saturates at sixteen on write.
// ----------------------------------------------------------------------------
module hnf_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [hnf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hnf_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  output hnf_pkg::cfg_t                   cfg
);

  hnf_pkg::cfg_t cfg_r, cfg_nxt;
  logic [hnf_pkg::CNT_W-1:0] min_wr;

  assign min_wr = cfg_wdata[hnf_pkg::CNT_W-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (hnf_pkg::cfg_idx_t'(cfg_index))
        hnf_pkg::CFG_MIN_DIGITS:
          cfg_nxt.min_digits = (min_wr > hnf_pkg::MAX_DIGITS) ? hnf_pkg::MAX_DIGITS : min_wr;
        hnf_pkg::CFG_GROUPING_ON:   cfg_nxt.grouping_on   = cfg_wdata[0];
        hnf_pkg::CFG_PREFIX_LENGTH:
          cfg_nxt.prefix_length = cfg_wdata[hnf_pkg::PRE_IDX_W-1:0];
        hnf_pkg::CFG_PREFIX_CHARS:  cfg_nxt.prefix_chars  = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_digits    <= 5'd1;
      cfg_r.grouping_on   <= 1'b0;
      cfg_r.prefix_length <= '0;
      cfg_r.prefix_chars  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* hdl/hnf_in_stage.sv */
// ----------------------------------------------------------------------------
// Hex formatter input stage
// One-entry input register; counts significant nibbles as the beat lands.
// ----------------------------------------------------------------------------
module hnf_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  hnf_num_if.sink          in_num,
  input  logic             take,
  output logic             item_valid,
  output hnf_pkg::item_t   item
);

  logic           valid_r, valid_nxt;
  hnf_pkg::item_t item_r;
  logic [hnf_pkg::CNT_W-1:0] sig;
  logic           accept;

  // highest nonzero nibble sets the count; a zero value keeps one digit
  always_comb begin
    sig = 5'd1;
    for (int i = 1; i < hnf_pkg::NIBBLES; i++) begin
      if (|in_num.number_in[4*i +: 4]) sig = 5'(i + 1);
    end
  end

  assign in_num.ready = !valid_r || take;
  assign accept       = in_num.valid && in_num.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept)    valid_nxt = 1'b1;
    else if (take) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.value <= in_num.number_in;
      item_r.sig   <= sig;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* hdl/hnf_char_seq.sv */
// ----------------------------------------------------------------------------
// Hex formatter character sequencer
// Walks prefix, padding, digits and group spaces; one character per beat.
// ----------------------------------------------------------------------------
`include "hex_number_formatter_core_defines.svh"

module hnf_char_seq #(
  parameter int PREFIX_CHARS = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  hnf_pkg::cfg_t    cfg,
  input  logic             item_valid,
  input  hnf_pkg::item_t   item,
  output logic             take,
  hnf_char_if.source       out_chr
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREFIX = 5'b00010,
    S_PAD    = 5'b00100,
    S_DIGIT  = 5'b01000,
    S_SPACE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [hnf_pkg::NUM_W-1:0]     val_r, val_nxt;
  logic [hnf_pkg::PRE_IDX_W-1:0] pre_r, pre_nxt;
  logic [hnf_pkg::CNT_W-1:0]     pad_r, pad_nxt;
  logic [hnf_pkg::CNT_W-1:0]     dig_r, dig_nxt;
  logic                          ov_r, ov_nxt;
  logic [hnf_pkg::CHAR_W-1:0]    och_r, och_nxt;
  logic                          olast_r, olast_nxt;

  logic [hnf_pkg::PRE_IDX_W-1:0] plen;
  logic [hnf_pkg::CNT_W-1:0]     want, load_pad, dig_dec;
  logic [3:0]                    nib_idx;
  logic [hnf_pkg::CHAR_W-1:0]    ch, pfx_ch;
  logic                          adv, finish, last;

  always_comb begin
    plen = cfg.prefix_length;
    if (int'(cfg.prefix_length) > PREFIX_CHARS) plen = hnf_pkg::PRE_IDX_W'(PREFIX_CHARS);
  end

  assign want     = (cfg.min_digits == '0) ? 5'd1 : cfg.min_digits;
  assign load_pad = (want > item.sig) ? (want - item.sig) : '0;

  // only four codes are held; later prefix slots read as zero
  assign pfx_ch  = pre_r[2] ? '0 : cfg.prefix_chars[pre_r[1:0]*hnf_pkg::CHAR_W +: hnf_pkg::CHAR_W];
  assign dig_dec = dig_r - 5'd1;
  assign nib_idx = dig_dec[3:0];

  assign adv    = (state_r != S_IDLE) && (!ov_r || out_chr.ready);
  assign finish = adv && (state_r == S_DIGIT) && (dig_r == 5'd1);
  assign take   = item_valid && ((state_r == S_IDLE) || finish);

  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    pre_nxt   = pre_r;
    pad_nxt   = pad_r;
    dig_nxt   = dig_r;
    ch        = hnf_pkg::CHAR_ZERO;
    last      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
      end
      S_PREFIX: begin
        ch = pfx_ch;
        if (adv) begin
          pre_nxt = pre_r + 3'd1;
          if (pre_nxt == plen) state_nxt = (pad_r != '0) ? S_PAD : S_DIGIT;
        end
      end
      S_PAD: begin
        ch = hnf_pkg::CHAR_ZERO;
        if (adv) begin
          pad_nxt = pad_r - 5'd1;
          if (pad_r == 5'd1) state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        ch   = hnf_pkg::HEX_GLYPHS[val_r[nib_idx*4 +: 4]];
        last = (dig_r == 5'd1);
        if (adv) begin
          dig_nxt = dig_dec;
          if (dig_r == 5'd1)                           state_nxt = S_IDLE;
          else if (cfg.grouping_on && dig_dec[1:0] == 2'd0) state_nxt = S_SPACE;
        end
      end
      S_SPACE: begin
        ch = hnf_pkg::CHAR_SPACE;
        if (adv) state_nxt = S_DIGIT;
      end
      default: state_nxt = S_IDLE;
    endcase

    // next number starts on the same edge the last digit leaves
    if (take) begin
      val_nxt = item.value;
      dig_nxt = item.sig;
      pad_nxt = load_pad;
      pre_nxt = '0;
      if (plen != '0)          state_nxt = S_PREFIX;
      else if (load_pad != '0) state_nxt = S_PAD;
      else                     state_nxt = S_DIGIT;
    end
  end

  always_comb begin
    ov_nxt    = ov_r;
    och_nxt   = och_r;
    olast_nxt = olast_r;
    if (adv) begin
      ov_nxt    = 1'b1;
      och_nxt   = ch;
      olast_nxt = last;
    end else if (out_chr.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    pre_r   <= pre_nxt;
    pad_r   <= pad_nxt;
    dig_r   <= dig_nxt;
    och_r   <= och_nxt;
    olast_r <= olast_nxt;
  end

  assign out_chr.valid    = ov_r;
  assign out_chr.out_char = och_r;
  assign out_chr.is_last  = olast_r;

  `HNF_ASSERT_NOW(a_digit_cnt, state_r == S_DIGIT, dig_r != '0 && dig_r <= hnf_pkg::MAX_DIGITS, "digit count out of range")
  `HNF_ASSERT_NOW(a_pad_cnt, state_r == S_PAD, pad_r != '0, "padding state with nothing left")
  `HNF_ASSERT_NOW(a_space_pos, state_r == S_SPACE, dig_r != '0 && dig_r[1:0] == 2'd0, "group space off a group boundary")
  `HNF_ASSERT_NEXT(a_space_then_digit, adv && state_r == S_SPACE, state_r == S_DIGIT, "space not followed by a digit")

endmodule

/* hdl/hex_number_formatter_core.sv */
// ----------------------------------------------------------------------------
// Hex number formatter core
// Signed 64-bit value in, hexadecimal text out one character per beat.
// ----------------------------------------------------------------------------
// From idle, the first character passes the input register, the sequencer state
//   and the output register. Output: one character per cycle from the output
//   register while out_chr.ready holds; a number's text is prefix + max(min_digits,
//   significant digits) + group spaces characters (1..23 with four prefix slots).
// The next number is held in the input register and starts on the edge its
//   predecessor's last digit leaves, so texts follow with no gap.
// Reset (rst_n low, synchronous) empties both registers and restores config.
// ----------------------------------------------------------------------------
module hex_number_formatter_core #(
  parameter int PREFIX_CHARS = 4    // prefix_length saturates here; the field holds 0..7
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [hnf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hnf_pkg::CFG_DAT_W-1:0]   cfg_wdata,
  // number in
  hnf_num_if.sink                         in_num,
  // characters out
  hnf_char_if.source                      out_chr
);

  hnf_pkg::cfg_t  cfg;
  hnf_pkg::item_t item;
  logic           item_valid;
  logic           take;

  // live register values; the user must change them only between numbers (not enforced here)
  hnf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // one-number buffer: takes a new beat while the sequencer is still emitting
  hnf_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_num     (in_num),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // prefix -> zero padding -> digits (with group spaces) -> output register
  hnf_char_seq #(
    .PREFIX_CHARS (PREFIX_CHARS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_chr    (out_chr)
  );

endmodule
